// File: hw/rtl/l2lt_pkg.sv
// Shared types, constants and helpers for the label-to-line lookup table.
// Used by l2lt_store, l2lt_ctrl and label_to_line_table; depends on nothing.
`default_nettype none

package l2lt_pkg;

   localparam int TABLE_ENTRIES = 32;
   localparam int KEY_CHARS     = 7;
   localparam int KEY_W         = 56;
   localparam int LINE_W        = 16;
   localparam int IDX_W         = 5;
   localparam int CNT_W         = 6;
   localparam int MODE_W        = 2;
   localparam int STATUS_W      = 3;

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD   = 2'd0,
      MODE_FIND  = 2'd1,
      MODE_CLEAR = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_UPDATED = 3'd0,
      STATUS_ADDED   = 3'd1,
      STATUS_FULL    = 3'd2,
      STATUS_HIT     = 3'd3,
      STATUS_MISS    = 3'd4,
      STATUS_CLEARED = 3'd5
   } status_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [LINE_W-1:0] line;
   } entry_type;

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
   } mem_req_type;

   typedef struct packed {
      status_type        status;
      logic [LINE_W-1:0] found_line;
      logic [CNT_W-1:0]  entries_used;
   } result_type;

   // Keeps the top KEY_CHARS bytes up to the first zero byte; the rest reads as zero.
   function automatic logic [KEY_W-1:0] normalize_key(input logic [KEY_W-1:0] raw);
      logic [KEY_W-1:0] norm;
      logic             live;
      norm = '0;
      live = 1'b1;
      for (int i = 0; i < KEY_CHARS; i++) begin
         if (raw[KEY_W-1-8*i -: 8] == 8'h00) live = 1'b0;
         if (live) norm[KEY_W-1-8*i -: 8] = raw[KEY_W-1-8*i -: 8];
      end
      return norm;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/l2lt_store.sv
// Entry memory of the lookup table: key and line number per slot.
// One write port, one read port with registered read data; uses l2lt_pkg.
`default_nettype none

module l2lt_store
   import l2lt_pkg::*;
(
   input  wire logic        clock,
   input  wire mem_req_type mem_req,
   output entry_type        rd_data
);

   entry_type mem [TABLE_ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/l2lt_ctrl.sv
// Sequencer of the lookup table: walks the stored entries, compares keys and
// writes back updates or new entries. Uses l2lt_pkg and drives l2lt_store.
`default_nettype none

module l2lt_ctrl
   import l2lt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [MODE_W-1:0] in_mode,
   input  wire logic [KEY_W-1:0]  in_key,
   input  wire logic [LINE_W-1:0] in_line,
   output logic                   res_valid,
   input  wire logic              res_ready,
   output result_type             res,
   output mem_req_type            mem_req,
   input  wire entry_type         rd_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   mode_type          mode_ff, mode_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  issue_ff, issue_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  pend_idx_ff, pend_idx_in;
   result_type        res_ff, res_in;
   logic              hit;

   // The read data belongs to the slot issued in the previous cycle.
   assign hit = pend_ff && (rd_data.key == key_ff);

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      key_in      = key_ff;
      line_in     = line_ff;
      count_in    = count_ff;
      issue_in    = issue_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      res_in      = res_ff;
      mem_req     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               mode_in                = mode_type'(in_mode);
               key_in                 = normalize_key(in_key);
               line_in                = in_line;
               res_in.found_line      = '0;
               res_in.entries_used    = count_ff;
               issue_in               = '0;
               pend_in                = 1'b0;
               priority if (in_mode == MODE_CLEAR) begin
                  count_in            = '0;
                  res_in.status       = STATUS_CLEARED;
                  res_in.entries_used = '0;
                  state_in            = ST_DONE;
               end else if (in_mode == MODE_ADD && count_ff >= CNT_W'(TABLE_ENTRIES)) begin
                  res_in.status = STATUS_FULL;
                  state_in      = ST_DONE;
               end else if (in_mode == MODE_ADD || in_mode == MODE_FIND) begin
                  state_in = ST_SCAN;
               end else begin
                  res_in.status = STATUS_MISS;
                  state_in      = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            priority if (hit) begin
               pend_in  = 1'b0;
               state_in = ST_DONE;
               if (mode_ff == MODE_ADD) begin
                  mem_req.wr_en        = 1'b1;
                  mem_req.wr_addr      = pend_idx_ff;
                  mem_req.wr_data.key  = key_ff;
                  mem_req.wr_data.line = line_ff;
                  res_in.status        = STATUS_UPDATED;
               end else begin
                  res_in.status     = STATUS_HIT;
                  res_in.found_line = rd_data.line;
               end
            end else if (issue_ff < count_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = issue_ff[IDX_W-1:0];
               pend_in         = 1'b1;
               pend_idx_in     = issue_ff[IDX_W-1:0];
               issue_in        = issue_ff + CNT_W'(1);
            end else begin
               pend_in  = 1'b0;
               state_in = ST_DONE;
               if (mode_ff == MODE_ADD) begin
                  mem_req.wr_en        = 1'b1;
                  mem_req.wr_addr      = count_ff[IDX_W-1:0];
                  mem_req.wr_data.key  = key_ff;
                  mem_req.wr_data.line = line_ff;
                  count_in             = count_ff + CNT_W'(1);
                  res_in.status        = STATUS_ADDED;
                  res_in.entries_used  = count_ff + CNT_W'(1);
               end else begin
                  res_in.status = STATUS_MISS;
               end
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      key_ff      <= key_in;
      line_ff     <= line_in;
      issue_ff    <= issue_in;
      pend_idx_ff <= pend_idx_in;
      res_ff      <= res_in;
   end

   assign in_ready  = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res       = res_ff;

endmodule

`default_nettype wire

// File: hw/rtl/label_to_line_table.sv
// Top level of the label-to-line lookup table: stream ports, result register.
// Instantiates l2lt_ctrl and l2lt_store; uses l2lt_pkg.
//
//   channel  direction  tdata (low bit up)              tuser
//   req      in         label_key[55:0], line[71:56]    mode[1:0]
//   rsp      out        found_line[15:0], used[21:16]   status[2:0]
//
// One beat is handled at a time. An add or find walks the valid entries (up to
// 32) before its result reaches the result register, since the single memory
// read port delivers one entry a cycle; a clear, a full add or an unused mode
// reaches the result register without a walk. A new beat is taken once the
// previous result moves into the result register, even while rsp stalls.
// Synchronous reset empties the table at once; no clearing pass is needed.
`default_nettype none

module label_to_line_table
   import l2lt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,  // label_key[55:0], line_number[71:56]
   input  wire logic [1:0]  req_tuser,  // mode[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,  // found_line[15:0], entries_used[21:16], zero
   output logic [2:0]       rsp_tuser   // status[2:0]
);

   mem_req_type mem_req;
   entry_type   rd_data;
   result_type  res;
   logic        res_valid;
   logic        res_ready;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_res_ff, rsp_res_in;

   l2lt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_mode   (req_tuser),
      .in_key    (req_tdata[KEY_W-1:0]),
      .in_line   (req_tdata[KEY_W+LINE_W-1:KEY_W]),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .mem_req   (mem_req),
      .rd_data   (rd_data)
   );

   l2lt_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_res_ff.entries_used, rsp_res_ff.found_line};
   assign rsp_tuser  = rsp_res_ff.status;

`ifndef SYNTHESIS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[21:16] <= CNT_W'(TABLE_ENTRIES)))
      else $error("entries_used beyond table size");

   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == STATUS_CLEARED) |-> (rsp_tdata[21:16] == '0))
      else $error("clear left entries behind");

   a_found_only_on_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STATUS_HIT) |-> (rsp_tdata[15:0] == '0))
      else $error("found_line set without a hit");

   a_no_take_while_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second beat taken while one is in work");
`endif

endmodule

`default_nettype wire
